FILE: hdl/fwrk_pkg.sv
package fwrk_pkg;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 31;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    // Control word broadcast from the sequencer to every cell.
    typedef struct packed {
        logic clear;      // drop the match flags ahead of a search
        logic sweep;      // compare and pass the match flag one cell on
        logic shift_all;  // every cell takes its tail-side neighbor (pop)
        logic shift_hit;  // flagged cells take their neighbor (remove)
        logic load;       // the cell at the tail takes the key (append)
    } t_cell_ctrl;

endpackage

FILE: hdl/fwrk_cell.sv
module fwrk_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fwrk_pkg::t_cell_ctrl       i_ctrl,
    input  logic                       i_live,
    input  logic                       i_tail,
    input  logic [fwrk_pkg::ID_W-1:0]  i_key,
    input  logic [fwrk_pkg::ID_W-1:0]  i_next_data,
    input  logic                       i_prev_hit,
    output logic [fwrk_pkg::ID_W-1:0]  o_data,
    output logic                       o_hit
);

    logic [fwrk_pkg::ID_W-1:0] r_data;
    logic                      r_hit;
    logic                      w_match;

    // The flag means: a match lies at this cell or nearer the head.
    assign w_match = i_live && (r_data == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.sweep) begin
            r_hit <= r_hit | w_match | i_prev_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_all || (i_ctrl.shift_hit && r_hit)) begin
            r_data <= i_next_data;
        end else if (i_ctrl.load && i_tail) begin
            r_data <= i_key;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

FILE: hdl/fifo_with_remove_by_key.sv
// A bounded first-in first-out queue of 31-bit identifiers, built as a row of
// DEPTH cells with the head in cell 0. A command is taken at a clock edge where
// start is high and busy is low, and exactly one result beat follows: it is on
// o_status, o_head_id and o_entry_count for one cycle, marked by o_valid, and
// the receiver cannot stall it, so it must take every beat as it comes.
// Append, pop and peek never raise busy: the result beat appears in the cycle
// after the command, so such commands may be issued back to back. A remove
// walks a match flag from the head toward the tail one cell per cycle, and
// then closes the gap; busy is high through the walk and the gap closing, and
// the result beat appears in the first cycle with busy low again. A new
// command may be taken in that same cycle. The flag walk is what sets the
// length of a remove. o_entry_count reports the count after the command,
// truncated to its low five bits. The entries themselves need no reset; only
// the count and control are cleared.
module fifo_with_remove_by_key #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [fwrk_pkg::CMD_W-1:0]          i_cmd,
    input  logic [fwrk_pkg::ID_W-1:0]           i_request_id,
    output logic                                o_valid,
    output logic [fwrk_pkg::STATUS_W-1:0]       o_status,
    output logic [fwrk_pkg::ID_W-1:0]           o_head_id,
    output logic [fwrk_pkg::COUNT_W-1:0]        o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]                      r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [SW-1:0]                   r_sweep, n_sweep;
    logic [fwrk_pkg::ID_W-1:0]       r_key, n_key;
    logic                            r_valid, n_valid;
    logic [fwrk_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [fwrk_pkg::ID_W-1:0]       r_head, n_head;

    fwrk_pkg::t_cell_ctrl            w_ctrl;
    logic                            w_accept;
    logic [fwrk_pkg::ID_W-1:0]       w_cell_key;
    logic [fwrk_pkg::ID_W-1:0]       w_data [DEPTH];
    logic [DEPTH-1:0]                w_hit;
    logic [CW+fwrk_pkg::COUNT_W-1:0] w_count_ext;

    assign w_accept = start && (r_state == S_IDLE);

    // The key bus carries the new identifier during an append and the held
    // search key while a remove is under way.
    assign w_cell_key = w_accept ? i_request_id : r_key;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [fwrk_pkg::ID_W-1:0] w_next;
            logic                      w_prev;
            if (g == DEPTH - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_data[g+1];
            end
            if (g == 0) begin : g_first
                assign w_prev = 1'b0;
            end else begin : g_rest
                assign w_prev = w_hit[g-1];
            end
            fwrk_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_live      (CW'(g) < r_count),
                .i_tail      (CW'(g) == r_count),
                .i_key       (w_cell_key),
                .i_next_data (w_next),
                .i_prev_hit  (w_prev),
                .o_data      (w_data[g]),
                .o_hit       (w_hit[g])
            );
        end
    endgenerate

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_sweep  = r_sweep;
        n_key    = r_key;
        n_valid  = 1'b0;
        n_status = r_status;
        n_head   = r_head;
        w_ctrl   = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_valid  = 1'b1;
                    n_status = fwrk_pkg::STATUS_MISS;
                    n_head   = '0;
                    case (i_cmd)
                        fwrk_pkg::CMD_APPEND: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = fwrk_pkg::STATUS_FULL;
                            end else begin
                                w_ctrl.load = 1'b1;
                                n_count     = r_count + CW'(1);
                                n_status    = fwrk_pkg::STATUS_DONE;
                            end
                        end
                        fwrk_pkg::CMD_POP: begin
                            if (r_count != '0) begin
                                w_ctrl.shift_all = 1'b1;
                                n_count          = r_count - CW'(1);
                                n_head           = w_data[0];
                                n_status         = fwrk_pkg::STATUS_DONE;
                            end
                        end
                        fwrk_pkg::CMD_PEEK: begin
                            if (r_count != '0) begin
                                n_head   = w_data[0];
                                n_status = fwrk_pkg::STATUS_DONE;
                            end
                        end
                        fwrk_pkg::CMD_REMOVE: begin
                            // The result beat is held back until the gap closes.
                            n_valid      = 1'b0;
                            w_ctrl.clear = 1'b1;
                            n_key        = i_request_id;
                            n_sweep      = '0;
                            n_state      = S_SWEEP;
                        end
                        default: begin
                            n_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                // After DEPTH steps every cell knows whether a match sits at
                // or before it, which marks the cells that must move.
                w_ctrl.sweep = 1'b1;
                n_sweep      = r_sweep + SW'(1);
                if (r_sweep == SW'(DEPTH - 1)) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_valid  = 1'b1;
                n_head   = '0;
                n_state  = S_IDLE;
                if (w_hit[DEPTH-1]) begin
                    w_ctrl.shift_hit = 1'b1;
                    n_count          = r_count - CW'(1);
                    n_status         = fwrk_pkg::STATUS_DONE;
                end else begin
                    n_status = fwrk_pkg::STATUS_MISS;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_sweep <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_sweep <= n_sweep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_status <= n_status;
        r_head   <= n_head;
    end

    // The count rides along with the result beat; only its low bits leave.
    assign w_count_ext   = {{fwrk_pkg::COUNT_W{1'b0}}, r_count};
    assign o_entry_count = w_count_ext[fwrk_pkg::COUNT_W-1:0];

    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_head_id = r_head;

endmodule

FILE: tb/sv/fifo_with_remove_by_key_tb.sv
`timescale 1ns / 100ps

module fifo_with_remove_by_key_tb;

    localparam int QUEUE_DEPTH = 16;
    // Commands in the random part; the directed table adds about thirty more.
    localparam int RANDOM_CMDS = 1720;
    // Removes hold busy through sweep and shift, so this covers any beat still in flight.
    localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;
    localparam logic [fwrk_pkg::ID_W-1:0] ID_MAX = {fwrk_pkg::ID_W{1'b1}};

    // One result beat as the block reports it.
    typedef struct packed {
        logic [fwrk_pkg::STATUS_W-1:0] status;
        logic [fwrk_pkg::ID_W-1:0]     head_id;
        logic [fwrk_pkg::COUNT_W-1:0]  count;
    } t_queue_result;

    // One row of the directed table. A row with reps above one repeats the
    // command with the identifier counting up by one each time. Where fixed is
    // set, the expected beat is the one typed into the row.
    typedef struct packed {
        logic [fwrk_pkg::CMD_W-1:0] cmd;
        logic [fwrk_pkg::ID_W-1:0]  id;
        logic [4:0]                 reps;
        logic                       fixed;
        t_queue_result              res;
    } t_step_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [fwrk_pkg::CMD_W-1:0]    i_cmd = '0;
    logic [fwrk_pkg::ID_W-1:0]     i_request_id = '0;
    logic                          o_valid;
    logic [fwrk_pkg::STATUS_W-1:0] o_status;
    logic [fwrk_pkg::ID_W-1:0]     o_head_id;
    logic [fwrk_pkg::COUNT_W-1:0]  o_entry_count;

    // Typed-in expectation, driven alongside the command it belongs to so that
    // the checker sees both at the same accepting edge.
    logic          exp_fixed = 1'b0;
    t_queue_result exp_fixed_val = '0;

    // The predicted queue contents, head first, and the beats still owed.
    logic [fwrk_pkg::ID_W-1:0] shadow_ids[$];
    t_queue_result             owed_results[$];

    int n_sent = 0;
    int n_beats = 0;
    int n_fail = 0;

    t_step_row step_rows[$];

    fifo_with_remove_by_key #(
        .DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_request_id  (i_request_id),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_head_id     (o_head_id),
        .o_entry_count (o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Only the first ten failures are printed; the rest are just counted.
    function automatic void flag_failure(input string msg);
        n_fail++;
        if (n_fail <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // Applies one command to the shadow queue and returns the beat it should
    // produce. Removal takes the match nearest the head and keeps the order of
    // the rest; a failed command leaves the queue as it was.
    function automatic t_queue_result predict_cmd(input logic [fwrk_pkg::CMD_W-1:0] c,
                                                  input logic [fwrk_pkg::ID_W-1:0] id);
        t_queue_result r;
        int hit;
        r.status = fwrk_pkg::STATUS_MISS;
        r.head_id = '0;
        hit = -1;
        case (c)
            fwrk_pkg::CMD_APPEND: begin
                if (shadow_ids.size() >= QUEUE_DEPTH) begin
                    r.status = fwrk_pkg::STATUS_FULL;
                end else begin
                    shadow_ids.push_back(id);
                    r.status = fwrk_pkg::STATUS_DONE;
                end
            end
            fwrk_pkg::CMD_POP: begin
                if (shadow_ids.size() > 0) begin
                    r.head_id = shadow_ids.pop_front();
                    r.status = fwrk_pkg::STATUS_DONE;
                end
            end
            fwrk_pkg::CMD_PEEK: begin
                if (shadow_ids.size() > 0) begin
                    r.head_id = shadow_ids[0];
                    r.status = fwrk_pkg::STATUS_DONE;
                end
            end
            fwrk_pkg::CMD_REMOVE: begin
                for (int i = 0; i < shadow_ids.size(); i++) begin
                    if (hit < 0 && shadow_ids[i] == id) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    shadow_ids.delete(hit);
                    r.status = fwrk_pkg::STATUS_DONE;
                end
            end
            default: begin
                r.status = fwrk_pkg::STATUS_MISS;
            end
        endcase
        r.count = fwrk_pkg::COUNT_W'(shadow_ids.size());
        return r;
    endfunction

    // Identifiers lean toward a tiny pool so that duplicates and remove hits
    // are common, with the bit-pattern extremes mixed in and the rest spread
    // over the whole 31-bit range.
    function automatic logic [fwrk_pkg::ID_W-1:0] pick_id();
        int roll;
        logic [fwrk_pkg::ID_W-1:0] id;
        roll = $urandom_range(99);
        if (roll < 25) begin
            id = fwrk_pkg::ID_W'($urandom_range(3));
        end else if (roll < 35) begin
            case ($urandom_range(3))
                0: id = '0;
                1: id = ID_MAX;
                2: id = 31'h2AAA_AAAA;
                default: id = 31'h5555_5555;
            endcase
        end else begin
            id = fwrk_pkg::ID_W'($urandom);
        end
        return id;
    endfunction

    task automatic add_row(input logic [fwrk_pkg::CMD_W-1:0] c,
                           input logic [fwrk_pkg::ID_W-1:0] id,
                           input int reps, input logic fixed,
                           input logic [fwrk_pkg::STATUS_W-1:0] st,
                           input logic [fwrk_pkg::ID_W-1:0] head,
                           input logic [fwrk_pkg::COUNT_W-1:0] cnt);
        t_step_row row;
        row.cmd = c;
        row.id = id;
        row.reps = 5'(reps);
        row.fixed = fixed;
        row.res.status = st;
        row.res.head_id = head;
        row.res.count = cnt;
        step_rows.push_back(row);
    endtask

    // Holds start low for the given number of cycles, with junk on the command lines.
    task automatic idle_for(input int cycles);
        repeat (cycles) begin
            start <= 1'b0;
            i_cmd <= fwrk_pkg::CMD_W'($urandom);
            i_request_id <= fwrk_pkg::ID_W'($urandom);
            exp_fixed <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Idles before roughly 22 commands in a hundred, unless idling is off.
    task automatic pace(input logic allow_idle);
        if (allow_idle && $urandom_range(99) < 22) begin
            idle_for(1);
        end
    endtask

    // Presents one command and returns at the edge that accepts it. Start is
    // left high so that the next command can follow without a bubble.
    task automatic issue_cmd(input logic [fwrk_pkg::CMD_W-1:0] c,
                             input logic [fwrk_pkg::ID_W-1:0] id,
                             input logic fixed, input t_queue_result res);
        start <= 1'b1;
        i_cmd <= c;
        i_request_id <= id;
        exp_fixed <= fixed;
        exp_fixed_val <= res;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        n_sent++;
    endtask

    // Checker. Everything here is sampled at the rising edge, so it sees the
    // values that the block saw. A result beat is compared with the oldest owed
    // beat first; a command accepted at the same edge is predicted after that.
    always @(posedge i_clk) begin
        t_queue_result want;
        t_queue_result pred;
        if (i_rst_n && $isunknown(o_valid)) begin
            flag_failure("o_valid is unknown after reset");
        end
        if (i_rst_n && o_valid === 1'b1) begin
            n_beats++;
            if (owed_results.size() == 0) begin
                flag_failure($sformatf("beat %0d arrived with no command waiting for it",
                                       n_beats));
            end else begin
                want = owed_results.pop_front();
                if (o_status !== want.status || o_head_id !== want.head_id
                        || o_entry_count !== want.count) begin
                    flag_failure($sformatf(
                        "beat %0d: expected status %0d head %h count %0d, got %0d %h %0d",
                        n_beats, want.status, want.head_id, want.count,
                        o_status, o_head_id, o_entry_count));
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            pred = predict_cmd(i_cmd, i_request_id);
            owed_results.push_back(exp_fixed ? exp_fixed_val : pred);
        end
    end

    initial begin
        t_step_row row;
        logic [fwrk_pkg::CMD_W-1:0] c;
        logic [fwrk_pkg::ID_W-1:0] id;
        logic filling;
        int roll;
        int occ;

        // Empty queue: pop, peek and remove all miss, and the count stays zero.
        add_row(fwrk_pkg::CMD_POP,    '0,     1, 1'b1, fwrk_pkg::STATUS_MISS, '0, 5'd0);
        add_row(fwrk_pkg::CMD_PEEK,   ID_MAX, 1, 1'b1, fwrk_pkg::STATUS_MISS, '0, 5'd0);
        add_row(fwrk_pkg::CMD_REMOVE, ID_MAX, 1, 1'b1, fwrk_pkg::STATUS_MISS, '0, 5'd0);
        // One entry in and out again; the next append must land at the head.
        add_row(fwrk_pkg::CMD_APPEND, ID_MAX, 1, 1'b1, fwrk_pkg::STATUS_DONE, '0,     5'd1);
        add_row(fwrk_pkg::CMD_PEEK,   '0,     1, 1'b1, fwrk_pkg::STATUS_DONE, ID_MAX, 5'd1);
        add_row(fwrk_pkg::CMD_POP,    '0,     1, 1'b1, fwrk_pkg::STATUS_DONE, ID_MAX, 5'd0);
        add_row(fwrk_pkg::CMD_APPEND, '0,     1, 1'b1, fwrk_pkg::STATUS_DONE, '0,     5'd1);
        add_row(fwrk_pkg::CMD_PEEK,   ID_MAX, 1, 1'b1, fwrk_pkg::STATUS_DONE, '0,     5'd1);
        // Fill up with a duplicate near the head, then try one append too many.
        add_row(fwrk_pkg::CMD_APPEND, 31'h2AAA_AAAA, 1,  1'b0, fwrk_pkg::STATUS_DONE, '0, 5'd0);
        add_row(fwrk_pkg::CMD_APPEND, 31'h5555_5555, 1,  1'b0, fwrk_pkg::STATUS_DONE, '0, 5'd0);
        add_row(fwrk_pkg::CMD_APPEND, 31'h2AAA_AAAA, 1,  1'b0, fwrk_pkg::STATUS_DONE, '0, 5'd0);
        add_row(fwrk_pkg::CMD_APPEND, 31'h0000_0100, 12, 1'b0, fwrk_pkg::STATUS_DONE, '0, 5'd0);
        add_row(fwrk_pkg::CMD_APPEND, 31'h0000_1234, 1,  1'b1, fwrk_pkg::STATUS_FULL, '0, 5'd16);
        // Remove the first of the duplicates, then the head, then the tail,
        // and finally a key that is not there.
        add_row(fwrk_pkg::CMD_REMOVE, 31'h2AAA_AAAA, 1, 1'b0, fwrk_pkg::STATUS_DONE, '0, 5'd0);
        add_row(fwrk_pkg::CMD_REMOVE, '0,            1, 1'b0, fwrk_pkg::STATUS_DONE, '0, 5'd0);
        add_row(fwrk_pkg::CMD_REMOVE, 31'h0000_010B, 1, 1'b0, fwrk_pkg::STATUS_DONE, '0, 5'd0);
        add_row(fwrk_pkg::CMD_REMOVE, ID_MAX,        1, 1'b1, fwrk_pkg::STATUS_MISS, '0, 5'd13);
        // The head now holds the value that followed the removed duplicate,
        // and the surviving duplicate comes right after it.
        add_row(fwrk_pkg::CMD_POP,    '0, 1, 1'b0, fwrk_pkg::STATUS_DONE, '0, 5'd0);
        add_row(fwrk_pkg::CMD_PEEK,   '0, 1, 1'b0, fwrk_pkg::STATUS_DONE, '0, 5'd0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (step_rows[k]) begin
            row = step_rows[k];
            for (int r = 0; r < row.reps; r++) begin
                pace(1'b1);
                issue_cmd(row.cmd, row.id + fwrk_pkg::ID_W'(r), row.fixed, row.res);
            end
        end

        // Random part. The mix swings between a filling phase and a draining
        // phase so that the queue keeps passing through full and empty. Most
        // removes aim at an entry that is really held, so the gap-closing path
        // gets exercised at every position.
        filling = 1'b1;
        for (int k = 0; k < RANDOM_CMDS; k++) begin
            if (k == 300 || k == 1200) begin
                // Let the block drain completely before going on.
                start <= 1'b0;
                do begin
                    @(posedge i_clk);
                end while (n_beats != n_sent);
            end else begin
                // Commands 600 through 899 go back to back with no idling.
                pace(!(k >= 600 && k < 900));
            end

            occ = shadow_ids.size();
            if (occ >= QUEUE_DEPTH && $urandom_range(3) == 0) begin
                filling = 1'b0;
            end else if (occ == 0 && $urandom_range(3) == 0) begin
                filling = 1'b1;
            end else if ($urandom_range(49) == 0) begin
                filling = !filling;
            end

            roll = $urandom_range(99);
            id = pick_id();
            if (roll < 10) begin
                c = fwrk_pkg::CMD_W'($urandom);
                id = fwrk_pkg::ID_W'($urandom);
            end else begin
                roll = $urandom_range(99);
                if (roll < (filling ? 60 : 20)) begin
                    c = fwrk_pkg::CMD_APPEND;
                end else if (roll < (filling ? 72 : 55)) begin
                    c = fwrk_pkg::CMD_POP;
                end else if (roll < (filling ? 82 : 65)) begin
                    c = fwrk_pkg::CMD_PEEK;
                end else begin
                    c = fwrk_pkg::CMD_REMOVE;
                    if (occ > 0 && $urandom_range(99) < 65) begin
                        id = shadow_ids[$urandom_range(occ - 1)];
                    end
                end
            end
            issue_cmd(c, id, 1'b0, '0);
        end

        start <= 1'b0;
        while (n_beats != n_sent) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (owed_results.size() != 0) begin
            flag_failure($sformatf("%0d result beats never arrived", owed_results.size()));
        end

        if (n_fail == 0) begin
            $display("** fifo_with_remove_by_key: PASSED **");
        end else begin
            $display("** fifo_with_remove_by_key: FAILED **");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under half a millisecond.
    initial begin
        #2000000;
        $display("** fifo_with_remove_by_key: FAILED **");
        $finish;
    end

endmodule
